// ===== hdl/svm_pkg.sv =====
// Shared types, opcode and status codes for the stack machine step unit.
package svm_pkg;

  typedef enum logic [5:0] {
    OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
    OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
    OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
    OP_SC   = 6'd12, OP_PUSH = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
    OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
    OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_OPEN = 6'd30, OP_READ = 6'd31,
    OP_CLOS = 6'd32, OP_PRTF = 6'd33, OP_MALC = 6'd34, OP_MSET = 6'd35,
    OP_MCMP = 6'd36, OP_EXIT = 6'd37
  } opcode_e;

  typedef enum logic [1:0] {
    STS_RUN    = 2'd0,
    STS_EXITED = 2'd1,
    STS_UNSUP  = 2'd2,
    STS_FAULT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,
    MDU_DIV = 2'd1,
    MDU_MOD = 2'd2
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  function automatic logic [63:0] byte_sext(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

endpackage

// ===== hdl/svm_ram.sv =====
// Generic single-port RAM with registered read data.
module svm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/svm_alu.sv =====
// Combinational logic, add, subtract, compare and shift unit.
module svm_alu (
  input  svm_pkg::opcode_e op_i,
  input  logic [63:0]      x_i,
  input  logic [63:0]      a_i,
  output logic [63:0]      res_o
);

  logic [5:0] sh;

  assign sh = a_i[5:0];

  always_comb begin
    case (op_i)
      svm_pkg::OP_OR:  res_o = x_i | a_i;
      svm_pkg::OP_XOR: res_o = x_i ^ a_i;
      svm_pkg::OP_AND: res_o = x_i & a_i;
      svm_pkg::OP_EQ:  res_o = 64'(x_i == a_i);
      svm_pkg::OP_NE:  res_o = 64'(x_i != a_i);
      svm_pkg::OP_LT:  res_o = 64'($signed(x_i) < $signed(a_i));
      svm_pkg::OP_GT:  res_o = 64'($signed(x_i) > $signed(a_i));
      svm_pkg::OP_LE:  res_o = 64'($signed(x_i) <= $signed(a_i));
      svm_pkg::OP_GE:  res_o = 64'($signed(x_i) >= $signed(a_i));
      svm_pkg::OP_SHL: res_o = x_i << sh;
      svm_pkg::OP_SHR: res_o = 64'($signed(x_i) >>> sh);
      svm_pkg::OP_ADD: res_o = x_i + a_i;
      svm_pkg::OP_SUB: res_o = x_i - a_i;
      default:         res_o = x_i + a_i;
    endcase
  end

endmodule

// ===== hdl/svm_mdu.sv =====
// Iterative one-bit-per-cycle multiply, divide and modulo unit.
module svm_mdu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svm_pkg::mdu_req_t req_i,
  input  logic [63:0]       x_i,
  input  logic [63:0]       a_i,
  output logic              done_o,
  output logic [63:0]       result_o
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIX  = 3'b100
  } mstate_e;

  mstate_e          st_q, st_d;
  svm_pkg::mdu_op_e op_q, op_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [63:0]      p_q, p_d, m_q, m_d, b_q, b_d, res_q, res_d;
  logic             negq_q, negq_d, negr_q, negr_d, spec_q, spec_d, done_q, done_d;
  logic [63:0]      rs;
  logic             ge;

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    m_d    = m_q;
    b_d    = b_q;
    res_d  = res_q;
    negq_d = negq_q;
    negr_d = negr_q;
    spec_d = spec_q;
    done_d = 1'b0;
    rs     = {p_q[62:0], b_q[63]};
    ge     = rs >= m_q;
    unique case (st_q)
      M_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          cnt_d  = '0;
          p_d    = '0;
          spec_d = 1'b0;
          if (req_i.op == svm_pkg::MDU_MUL) begin
            m_d  = x_i;
            b_d  = a_i;
            st_d = M_RUN;
          end else if (a_i == 64'd0) begin
            spec_d = 1'b1;
            st_d   = M_FIX;
          end else if (a_i == '1) begin
            spec_d = 1'b1;
            p_d    = (req_i.op == svm_pkg::MDU_DIV) ? 64'd0 - x_i : 64'd0;
            st_d   = M_FIX;
          end else begin
            m_d    = a_i[63] ? 64'd0 - a_i : a_i;
            b_d    = x_i[63] ? 64'd0 - x_i : x_i;
            negq_d = x_i[63] ^ a_i[63];
            negr_d = x_i[63];
            st_d   = M_RUN;
          end
        end
      end
      M_RUN: begin
        if (op_q == svm_pkg::MDU_MUL) begin
          p_d = p_q + (b_q[0] ? m_q : 64'd0);
          m_d = m_q << 1;
          b_d = b_q >> 1;
        end else begin
          b_d = {b_q[62:0], ge};
          p_d = ge ? rs - m_q : rs;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          st_d = M_FIX;
        end
      end
      M_FIX: begin
        done_d = 1'b1;
        if (spec_q || op_q == svm_pkg::MDU_MUL) begin
          res_d = p_q;
        end else if (op_q == svm_pkg::MDU_DIV) begin
          res_d = negq_q ? 64'd0 - b_q : b_q;
        end else begin
          res_d = negr_q ? 64'd0 - p_q : p_q;
        end
        st_d = M_IDLE;
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    p_q    <= p_d;
    m_q    <= m_d;
    b_q    <= b_d;
    res_q  <= res_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    spec_q <= spec_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/stack_vm_instruction_step_unit.sv =====
// Stack machine step unit: executes one instruction per input transaction.
// After reset the unit zeroes its data memory, one word per cycle, and takes no instruction
// meanwhile. An instruction then passes through accept, execute and the hand-over of its
// result to the output register, which waits while that register holds an unaccepted
// result, plus a read step per data memory read: LI, LC, SI, EXIT and the ALU operations
// read once, LEV and SC read twice, since the single-port data memory serves one access
// per cycle. MUL, DIV and MOD also wait in the shared bit-serial multiply-divide unit,
// which takes a short path when dividing by zero or minus one. A result can wait in the
// output register while the next instruction is taken.
module stack_vm_instruction_step_unit #(
  parameter int MEM_WORDS  = 32768,
  parameter int PROG_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  opcode_i,
  input  logic [63:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [63:0] accumulator_out_o,
  output logic [1:0]  status_o,
  output logic [63:0] exit_value_o
);

  localparam int MAW = $clog2(MEM_WORDS);
  localparam int BAW = $clog2(MEM_WORDS * 8 + 1);
  localparam int PCW = $clog2(PROG_WORDS);
  localparam logic [63:0] MemBytes = 64'(MEM_WORDS) * 64'd8;
  localparam logic [63:0] ProgW    = 64'(PROG_WORDS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_MDU   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  function automatic logic [MAW-1:0] waddr(input logic [63:0] b);
    return b[MAW+2:3];
  endfunction

  state_e            state_q, state_d;
  logic [PCW-1:0]    pc_q, pc_d;
  logic [BAW-1:0]    sp_q, sp_d, bp_q, bp_d;
  logic [63:0]       acc_q, acc_d;
  logic              halted_q, halted_d;
  logic [1:0]        hcode_q, hcode_d;
  svm_pkg::opcode_e  op_q, op_d;
  logic [63:0]       opd_q, opd_d, t_q, t_d;
  logic [MAW-1:0]    clr_q, clr_d;
  logic [PCW-1:0]    res_npc_q, res_npc_d, out_npc_q, out_npc_d;
  logic [63:0]       res_acc_q, res_acc_d, out_acc_q, out_acc_d;
  logic [63:0]       res_exv_q, res_exv_d, out_exv_q, out_exv_d;
  logic [1:0]        res_st_q, res_st_d, out_st_q, out_st_d;
  logic              out_valid_q, out_valid_d;

  logic              ram_we;
  logic [MAW-1:0]    ram_addr;
  logic [63:0]       ram_wdata, ram_rdata, word;
  logic [63:0]       alu_res, mdu_res;
  logic              mdu_done;
  svm_pkg::mdu_req_t mdu_req;

  logic [63:0]       sp64, bp64, t64, down, up, neg_lim;
  logic [PCW:0]      pc1w, pc2w;
  logic [PCW-1:0]    pc1, pc2;
  logic              fin, fault, taken;
  svm_pkg::status_e  f_status;
  logic [PCW-1:0]    f_npc;
  logic [BAW-1:0]    f_nsp, f_nbp;
  logic [63:0]       f_nacc, f_exv;

  svm_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  svm_alu u_alu (
    .op_i (op_q),
    .x_i  (ram_rdata),
    .a_i  (acc_q),
    .res_o(alu_res)
  );

  svm_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mdu_req),
    .x_i     (ram_rdata),
    .a_i     (acc_q),
    .done_o  (mdu_done),
    .result_o(mdu_res)
  );

  assign sp64 = 64'(sp_q);
  assign bp64 = 64'(bp_q);
  assign pc1w = {1'b0, pc_q} + (PCW+1)'(1);
  assign pc2w = {1'b0, pc_q} + (PCW+1)'(2);
  assign pc1  = (pc1w >= (PCW+1)'(PROG_WORDS)) ? PCW'(pc1w - (PCW+1)'(PROG_WORDS))
                                               : pc1w[PCW-1:0];
  assign pc2  = (pc2w >= (PCW+1)'(PROG_WORDS)) ? PCW'(pc2w - (PCW+1)'(PROG_WORDS))
                                               : pc2w[PCW-1:0];

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    sp_d        = sp_q;
    bp_d        = bp_q;
    acc_d       = acc_q;
    halted_d    = halted_q;
    hcode_d     = hcode_q;
    op_d        = op_q;
    opd_d       = opd_q;
    t_d         = t_q;
    clr_d       = clr_q;
    res_npc_d   = res_npc_q;
    res_acc_d   = res_acc_q;
    res_exv_d   = res_exv_q;
    res_st_d    = res_st_q;
    out_npc_d   = out_npc_q;
    out_acc_d   = out_acc_q;
    out_exv_d   = out_exv_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    mdu_req     = '0;
    fin         = 1'b0;
    fault       = 1'b0;
    taken       = 1'b0;
    f_status    = svm_pkg::STS_RUN;
    f_npc       = pc1;
    f_nsp       = sp_q;
    f_nbp       = bp_q;
    f_nacc      = acc_q;
    f_exv       = '0;
    t64         = '0;
    down        = '0;
    up          = '0;
    neg_lim     = '0;
    word        = ram_rdata;

    unique case (state_q)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + MAW'(1);
        if (clr_q == MAW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = svm_pkg::opcode_e'(opcode_i);
          opd_d   = operand_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (halted_q) begin
          res_npc_d = pc_q;
          res_acc_d = acc_q;
          res_st_d  = hcode_q;
          res_exv_d = '0;
          state_d   = S_DONE;
        end else begin
          fin = 1'b1;
          unique case (op_q) inside
            svm_pkg::OP_LEA: begin
              f_nacc = bp64 + (opd_q << 3);
              f_npc  = pc2;
            end
            svm_pkg::OP_IMM: begin
              f_nacc = opd_q;
              f_npc  = pc2;
            end
            svm_pkg::OP_JMP: begin
              if (opd_q >= ProgW) fault = 1'b1;
              else f_npc = opd_q[PCW-1:0];
            end
            svm_pkg::OP_CALL: begin
              if (opd_q >= ProgW || sp64 < 64'd8) begin
                fault = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = waddr(sp64 - 64'd8);
                ram_wdata = 64'(pc2);
                f_nsp     = sp_q - BAW'(8);
                f_npc     = opd_q[PCW-1:0];
              end
            end
            svm_pkg::OP_JZ, svm_pkg::OP_JNZ: begin
              taken = (acc_q == 64'd0) == (op_q == svm_pkg::OP_JZ);
              if (!taken) f_npc = pc2;
              else if (opd_q >= ProgW) fault = 1'b1;
              else f_npc = opd_q[PCW-1:0];
            end
            svm_pkg::OP_ENT: begin
              t64     = sp64 - 64'd8;
              down    = t64 >> 3;
              up      = (MemBytes - t64) >> 3;
              neg_lim = 64'd0 - up;
              if (sp64 < 64'd8 || $signed(opd_q) > $signed(down) ||
                  $signed(opd_q) < $signed(neg_lim)) begin
                fault = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = waddr(t64);
                ram_wdata = bp64;
                f_nbp     = BAW'(t64);
                f_nsp     = BAW'(t64 - (opd_q << 3));
                f_npc     = pc2;
              end
            end
            svm_pkg::OP_ADJ: begin
              down    = sp64 >> 3;
              up      = (MemBytes - sp64) >> 3;
              neg_lim = 64'd0 - down;
              if ($signed(opd_q) > $signed(up) || $signed(opd_q) < $signed(neg_lim)) begin
                fault = 1'b1;
              end else begin
                f_nsp = BAW'(sp64 + (opd_q << 3));
                f_npc = pc2;
              end
            end
            svm_pkg::OP_LEV: begin
              if (bp64 + 64'd16 > MemBytes) begin
                fault = 1'b1;
              end else begin
                fin      = 1'b0;
                ram_addr = waddr(bp64);
                state_d  = S_RD1;
              end
            end
            svm_pkg::OP_LI: begin
              if (acc_q >= MemBytes || acc_q[2:0] != 3'd0) begin
                fault = 1'b1;
              end else begin
                fin      = 1'b0;
                ram_addr = waddr(acc_q);
                state_d  = S_RD1;
              end
            end
            svm_pkg::OP_LC: begin
              if (acc_q >= MemBytes) begin
                fault = 1'b1;
              end else begin
                fin      = 1'b0;
                ram_addr = waddr(acc_q);
                state_d  = S_RD1;
              end
            end
            svm_pkg::OP_PUSH: begin
              if (sp64 < 64'd8) begin
                fault = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = waddr(sp64 - 64'd8);
                ram_wdata = acc_q;
                f_nsp     = sp_q - BAW'(8);
              end
            end
            svm_pkg::OP_SI, svm_pkg::OP_SC, svm_pkg::OP_EXIT,
            [svm_pkg::OP_OR:svm_pkg::OP_MOD]: begin
              if (sp64 >= MemBytes) begin
                fault = 1'b1;
              end else begin
                fin      = 1'b0;
                ram_addr = waddr(sp64);
                state_d  = S_RD1;
              end
            end
            default: f_status = svm_pkg::STS_UNSUP;
          endcase
        end
      end
      S_RD1: begin
        unique case (op_q) inside
          svm_pkg::OP_LEV: begin
            t_d      = ram_rdata;
            ram_addr = waddr(bp64 + 64'd8);
            state_d  = S_RD2;
          end
          svm_pkg::OP_LI: begin
            fin    = 1'b1;
            f_nacc = ram_rdata;
          end
          svm_pkg::OP_LC: begin
            fin    = 1'b1;
            f_nacc = svm_pkg::byte_sext(ram_rdata[{acc_q[2:0], 3'b000} +: 8]);
          end
          svm_pkg::OP_SI: begin
            fin = 1'b1;
            if (ram_rdata >= MemBytes || ram_rdata[2:0] != 3'd0) begin
              fault = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_addr  = waddr(ram_rdata);
              ram_wdata = acc_q;
              f_nsp     = sp_q + BAW'(8);
            end
          end
          svm_pkg::OP_SC: begin
            if (ram_rdata >= MemBytes) begin
              fin   = 1'b1;
              fault = 1'b1;
            end else begin
              t_d      = ram_rdata;
              ram_addr = waddr(ram_rdata);
              state_d  = S_RD2;
            end
          end
          svm_pkg::OP_EXIT: begin
            fin      = 1'b1;
            f_status = svm_pkg::STS_EXITED;
            f_exv    = ram_rdata;
          end
          svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = (op_q == svm_pkg::OP_MUL) ? svm_pkg::MDU_MUL :
                            (op_q == svm_pkg::OP_DIV) ? svm_pkg::MDU_DIV : svm_pkg::MDU_MOD;
            state_d       = S_MDU;
          end
          default: begin
            fin    = 1'b1;
            f_nacc = alu_res;
            f_nsp  = sp_q + BAW'(8);
          end
        endcase
      end
      S_RD2: begin
        fin = 1'b1;
        if (op_q == svm_pkg::OP_LEV) begin
          if (t_q > MemBytes || t_q[2:0] != 3'd0 || ram_rdata >= ProgW) begin
            fault = 1'b1;
          end else begin
            f_nsp = BAW'(bp64 + 64'd16);
            f_nbp = BAW'(t_q);
            f_npc = ram_rdata[PCW-1:0];
          end
        end else begin
          word[{t_q[2:0], 3'b000} +: 8] = acc_q[7:0];
          ram_we    = 1'b1;
          ram_addr  = waddr(t_q);
          ram_wdata = word;
          f_nacc    = svm_pkg::byte_sext(acc_q[7:0]);
          f_nsp     = sp_q + BAW'(8);
        end
      end
      S_MDU: begin
        if (mdu_done) begin
          fin    = 1'b1;
          f_nacc = mdu_res;
          f_nsp  = sp_q + BAW'(8);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_npc_d   = res_npc_q;
          out_acc_d   = res_acc_q;
          out_st_d    = res_st_q;
          out_exv_d   = res_exv_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      if (fault) begin
        f_status = svm_pkg::STS_FAULT;
      end
      state_d   = S_DONE;
      res_st_d  = f_status;
      res_exv_d = f_exv;
      if (f_status != svm_pkg::STS_RUN) begin
        halted_d  = 1'b1;
        hcode_d   = f_status;
        res_npc_d = pc_q;
        res_acc_d = acc_q;
      end else begin
        pc_d      = f_npc;
        sp_d      = f_nsp;
        bp_d      = f_nbp;
        acc_d     = f_nacc;
        res_npc_d = f_npc;
        res_acc_d = f_nacc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= '0;
      sp_q        <= BAW'(MemBytes);
      bp_q        <= BAW'(MemBytes);
      acc_q       <= '0;
      halted_q    <= 1'b0;
      hcode_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      bp_q        <= bp_d;
      acc_q       <= acc_d;
      halted_q    <= halted_d;
      hcode_q     <= hcode_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    opd_q     <= opd_d;
    t_q       <= t_d;
    res_npc_q <= res_npc_d;
    res_acc_q <= res_acc_d;
    res_exv_q <= res_exv_d;
    res_st_q  <= res_st_d;
    out_npc_q <= out_npc_d;
    out_acc_q <= out_acc_d;
    out_exv_q <= out_exv_d;
    out_st_q  <= out_st_d;
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = 16'(out_npc_q);
  assign accumulator_out_o = out_acc_q;
  assign status_o          = out_st_q;
  assign exit_value_o      = out_exv_q;

endmodule

// ===== hdl/svm_checker.sv =====
// Port-level checks for the stack machine step unit, bound to the top level.
module svm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [5:0]  opcode_i,
  input logic [63:0] operand_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] next_pc_o,
  input logic [63:0] accumulator_out_o,
  input logic [1:0]  status_o,
  input logic [63:0] exit_value_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(opcode_i) && $stable(operand_i))
    else $error("instruction changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_pc_o) &&
    $stable(accumulator_out_o) && $stable(status_o) && $stable(exit_value_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready while executing");

  a_exit_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exit_value_o != 64'd0 |-> status_o == svm_pkg::STS_EXITED)
    else $error("exit value without exit status");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without execution");

endmodule

bind stack_vm_instruction_step_unit svm_checker u_svm_checker (.*);
